>>> sv/sha_pkg.sv
// SHA-256 hasher package: word types, core command/status structs,
// initial hash values, round constants and round functions. No dependencies.
`default_nettype none
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds   = 64;
    localparam logic [3:0]  LenHiIdx = 4'd14;
    localparam logic [3:0]  LenLoIdx = 4'd15;
    localparam logic [7:0]  PadByte  = 8'h80;

    localparam t_word INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic t_word bsig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word bsig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word ssig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word ssig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

>>> sv/sha_if.sv
// Stream interfaces: message byte beats in, digest word beats out.
// Uses nothing else.
`default_nettype none
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    modport source(output valid, data_byte, byte_valid, message_end, input ready);
    modport sink(input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source(output valid, digest_word, word_index, last_word, input ready);
    modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> sv/sha_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module sha_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/sha_core.sv
// SHA-256 compression: one round per cycle, hash words held here.
// Reads the block from the message RAM; depends on sha_pkg.
`default_nettype none
module sha_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire sha_pkg::t_core_cmd i_cmd,
    output sha_pkg::t_core_stat    o_stat,
    output logic [3:0]             o_raddr,
    input  wire [31:0]             i_rdata,
    output logic [7:0][31:0]       o_hash
);
    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_ADD  = 3'b100
    } t_cstate;

    t_cstate        r_state, n_state;
    logic [5:0]     r_cnt;
    logic           r_done;
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    sha_pkg::t_word w_new, w_t1, w_t2, w_ch, w_maj;

    always_comb begin
        if (r_cnt[5:4] == 2'b00) begin
            w_new = i_rdata;
        end else begin
            w_new = sha_pkg::ssig1(r_w[14]) + r_w[9] + sha_pkg::ssig0(r_w[1]) + r_w[0];
        end
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1  = r_v[7] + sha_pkg::bsig1(r_v[4]) + w_ch + sha_pkg::ROUND_K[r_cnt] + w_new;
        w_t2  = sha_pkg::bsig0(r_v[0]) + w_maj;
        o_raddr = (r_state == C_RUN) ? (r_cnt[3:0] + 4'd1) : 4'd0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_cmd.start) n_state = C_RUN;
            end
            C_RUN: begin
                if (r_cnt == 6'(sha_pkg::Rounds - 1)) n_state = C_ADD;
            end
            C_ADD: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= 6'd0;
            r_done  <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_ADD);
            if (r_state == C_RUN) r_cnt <= r_cnt + 6'd1;
            else r_cnt <= 6'd0;
            if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
            end else if (r_state == C_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_cmd.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_state == C_RUN) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    always_comb begin
        o_stat.busy = (r_state != C_IDLE);
        o_stat.done = r_done;
        for (int i = 0; i < 8; i++) o_hash[i] = r_h[i];
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == C_IDLE) else $error("core start while busy");
    a_done_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == C_ADD) else $error("done without final add");
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_RUN && r_cnt != 6'd63) |=> r_state == C_RUN)
        else $error("rounds cut short");
endmodule
`default_nettype wire

>>> sv/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher. Byte beats are taken only while idle; the beat
// that completes a 64-byte block starts a compression (load, one round per
// cycle in sha_core, then final add) during which input is held off.
// A message-end beat writes the padding words one per cycle into the block
// RAM, pausing while a compression runs; it runs one or two compressions,
// then presents eight digest word beats, word 0 first, and returns to the
// initial hash values. Depends on sha_pkg, sha_if, sha_ram and sha_core.
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sha_byte_if.sink     i_in,
    sha_digest_if.source o_out
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PADW  = 6'b000010,
        S_ZERO  = 6'b000100,
        S_LENLO = 6'b001000,
        S_COMP  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state               r_state, n_state, r_ret, n_ret;
    logic [5:0]           r_fill, n_fill;
    logic [60:0]          r_total, n_total;
    logic [31:0]          r_word, n_word;
    logic [3:0]           r_pidx, n_pidx;
    logic [2:0]           r_oidx, n_oidx;
    logic                 w_fire, w_ofire, w_we;
    logic [3:0]           w_waddr, w_raddr;
    logic [31:0]          w_wdata, w_rdata, w_pad;
    sha_pkg::t_core_cmd   w_cmd;
    sha_pkg::t_core_stat  w_stat;
    logic [7:0][31:0]     w_hash;

    sha_ram #(.WIDTH(32), .DEPTH(sha_pkg::BlkWords)) u_blk (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata),
        .o_hash  (w_hash)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign w_fire            = i_in.valid && i_in.ready;
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = w_hash[r_oidx];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);
    assign w_ofire           = o_out.valid && o_out.ready;

    always_comb begin
        w_pad = ((r_fill[1:0] == 2'b00) ? 32'd0 : r_word)
              | ({24'd0, sha_pkg::PadByte} << {~r_fill[1:0], 3'b000});
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_total = r_total;
        n_word  = r_word;
        n_pidx  = r_pidx;
        n_oidx  = r_oidx;
        w_we    = 1'b0;
        w_waddr = r_fill[5:2];
        w_wdata = 32'd0;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    if (i_in.byte_valid) begin
                        n_word = ((r_fill[1:0] == 2'b00) ? 32'd0 : r_word)
                               | ({24'd0, i_in.data_byte} << {~r_fill[1:0], 3'b000});
                        n_fill  = r_fill + 6'd1;
                        n_total = r_total + 61'd1;
                        if (r_fill[1:0] == 2'b11) begin
                            w_we    = 1'b1;
                            w_wdata = n_word;
                        end
                        if (r_fill == 6'd63) begin
                            w_cmd.start = 1'b1;
                            n_state     = S_COMP;
                            n_ret       = i_in.message_end ? S_PADW : S_IDLE;
                        end else if (i_in.message_end) begin
                            n_state = S_PADW;
                        end
                    end else if (i_in.message_end) begin
                        n_state = S_PADW;
                    end
                end
            end
            S_PADW: begin
                w_we    = 1'b1;
                w_wdata = w_pad;
                if (r_fill[5:2] == 4'd15) begin
                    w_cmd.start = 1'b1;
                    n_pidx      = 4'd0;
                    n_state     = S_COMP;
                    n_ret       = S_ZERO;
                end else begin
                    n_pidx  = r_fill[5:2] + 4'd1;
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                w_we    = 1'b1;
                w_waddr = r_pidx;
                if (r_pidx == sha_pkg::LenHiIdx) begin
                    w_wdata = r_total[60:29];
                    n_state = S_LENLO;
                end else begin
                    n_pidx = r_pidx + 4'd1;
                    if (r_pidx == 4'd15) begin
                        w_cmd.start = 1'b1;
                        n_state     = S_COMP;
                        n_ret       = S_ZERO;
                    end
                end
            end
            S_LENLO: begin
                w_we        = 1'b1;
                w_waddr     = sha_pkg::LenLoIdx;
                w_wdata     = {r_total[28:0], 3'b000};
                w_cmd.start = 1'b1;
                n_state     = S_COMP;
                n_ret       = S_OUT;
            end
            S_COMP: begin
                if (w_stat.done) n_state = r_ret;
            end
            S_OUT: begin
                if (w_ofire) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        w_cmd.init = 1'b1;
                        n_fill     = 6'd0;
                        n_total    = 61'd0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= 6'd0;
            r_total <= 61'd0;
            r_pidx  <= 4'd0;
            r_oidx  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_pidx  <= n_pidx;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    a_start_core_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_stat.busy) else $error("compression started while busy");
    a_digest_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ofire && o_out.last_word) |=> (r_state == S_IDLE && r_total == 61'd0
        && r_fill == 6'd0)) else $error("no restart after digest");
    a_comp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && !w_stat.done) |-> w_stat.busy)
        else $error("waiting on idle core");
endmodule
`default_nettype wire
